@@ design/fmc_pkg.sv @@
// Shared types and fixed constants of the fuzzy membership classifier.
package fmc_pkg;

  // Membership shape selected by the mode register.
  typedef enum logic [1:0] {
    MODE_TRI   = 2'd0,
    MODE_TRAP  = 2'd1,
    MODE_GAUSS = 2'd2,
    MODE_NONE  = 2'd3
  } mf_mode_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MF_MODE     = 3'd0,
    REG_LOWER_EDGE  = 3'd1,
    REG_UPPER_EDGE  = 3'd2,
    REG_PLATEAU_END = 3'd3,
    REG_SPREAD      = 3'd4,
    REG_THR_LOW     = 3'd5,
    REG_THR_MID     = 3'd6,
    REG_THR_HIGH    = 3'd7
  } cfg_reg_t;

  // Suitability class codes.
  typedef enum logic [2:0] {
    CLS_N  = 3'd0,
    CLS_S3 = 3'd1,
    CLS_S2 = 3'd2,
    CLS_S1 = 3'd3,
    CLS_NA = 3'd4
  } suit_class_t;

  // How the score of an item is produced.
  typedef enum logic [1:0] {
    KIND_FIXED = 2'd0,
    KIND_RATIO = 2'd1,
    KIND_GAUSS = 2'd2
  } item_kind_t;

  // Control word that travels with every pipeline stage.
  typedef struct packed {
    logic        vld;
    item_kind_t  kind;
    logic        fixed_one;
    suit_class_t cls;
    logic        cap;
    logic        g_zero;
    logic [4:0]  g_n;
  } ctl_t;

  // Gaussian datapath constants.
  localparam int SPREAD_W     = 31;
  localparam int D_W          = 21;
  localparam int D_FRAC_BITS  = 16;
  localparam int T_W          = 24;
  localparam int FRAC_W       = 16;
  localparam int TERM_W       = 32;
  localparam int ACC_W        = 33;
  localparam int TAYLOR_TERMS = 12;
  localparam int EXP_STEPS    = 31;
  localparam logic [D_W-1:0]   D_CAP      = 21'h10_0000;
  localparam logic [ACC_W-1:0] Q32_ONE    = 33'h1_0000_0000;
  localparam logic [30:0]      EXP_M1_Q32 = 31'd1580030169;

  // Threshold reset values in Q1.16.
  localparam logic [16:0] THR_LOW_RESET  = 17'd16384;
  localparam logic [16:0] THR_MID_RESET  = 17'd32768;
  localparam logic [16:0] THR_HIGH_RESET = 17'd49152;

endpackage

@@ design/fuzzy_membership_classifier.sv @@
// Fuzzy membership classifier: pipelined right-face membership score and class.
// The block takes one sample per clock cycle and never asserts busy. Each result
// is strobed on out_valid once its start transaction has passed input capture, shape
// decode and divider entry, the restoring divider (one quotient bit per stage),
// quotient scaling, series setup, the eleven three-stage exponential series terms,
// the 31 stages that apply the integer part of the gaussian exponent, rounding and
// the output register; results leave in the order they came in.
// Configuration registers may be written only while no transaction is in flight.
module fuzzy_membership_classifier #(
  parameter int VALUE_WIDTH     = 32,
  parameter int SCORE_FRAC_BITS = 16
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          start,
  output logic                                          busy,
  input  logic signed [VALUE_WIDTH-1:0]                 in_sample_value,
  output logic                                          out_valid,
  output logic [SCORE_FRAC_BITS:0]                      out_member_score,
  output logic [2:0]                                    out_suit_class,
  input  logic                                          cfg_we,
  input  logic [2:0]                                    cfg_index,
  input  logic [((VALUE_WIDTH > 31) ? VALUE_WIDTH : 31)-1:0] cfg_wdata
);

  localparam int VW     = VALUE_WIDTH;
  localparam int F      = SCORE_FRAC_BITS;
  localparam int SW     = F + 1;
  localparam int THR_W  = (SW > 17) ? SW : 17;
  localparam int DENW   = (VW > 35) ? VW : 35;
  localparam int QS     = (F > 20) ? F : 20;
  localparam int ACC_W  = fmc_pkg::ACC_W;
  localparam int TAY_ST = 3 * (fmc_pkg::TAYLOR_TERMS - 1);
  localparam int FRAC_LAST = 3 * (fmc_pkg::TAYLOR_TERMS - 2);
  localparam int EXP_N  = fmc_pkg::EXP_STEPS;
  localparam int LAT    = 7 + QS + TAY_ST + EXP_N;
  localparam logic [SW-1:0]    SCORE_ONE = {1'b1, {F{1'b0}}};
  localparam logic [THR_W-1:0] THR_ONE   = THR_W'(SCORE_ONE);

  // Configuration registers.
  fmc_pkg::mf_mode_t            mode_r;
  logic signed [VW-1:0]         lower_r;
  logic signed [VW-1:0]         upper_r;
  logic signed [VW-1:0]         plateau_r;
  logic [fmc_pkg::SPREAD_W-1:0] spread_r;
  logic [THR_W-1:0]             thr_low_r;
  logic [THR_W-1:0]             thr_mid_r;
  logic [THR_W-1:0]             thr_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= fmc_pkg::MODE_TRI;
      lower_r    <= '0;
      upper_r    <= VW'(65536);
      plateau_r  <= '0;
      spread_r   <= 31'd65536;
      thr_low_r  <= THR_W'(fmc_pkg::THR_LOW_RESET);
      thr_mid_r  <= THR_W'(fmc_pkg::THR_MID_RESET);
      thr_high_r <= THR_W'(fmc_pkg::THR_HIGH_RESET);
    end else if (cfg_we) begin
      unique case (fmc_pkg::cfg_reg_t'(cfg_index))
        fmc_pkg::REG_MF_MODE:     mode_r     <= fmc_pkg::mf_mode_t'(cfg_wdata[1:0]);
        fmc_pkg::REG_LOWER_EDGE:  lower_r    <= signed'(cfg_wdata[VW-1:0]);
        fmc_pkg::REG_UPPER_EDGE:  upper_r    <= signed'(cfg_wdata[VW-1:0]);
        fmc_pkg::REG_PLATEAU_END: plateau_r  <= signed'(cfg_wdata[VW-1:0]);
        fmc_pkg::REG_SPREAD:      spread_r   <= cfg_wdata[fmc_pkg::SPREAD_W-1:0];
        fmc_pkg::REG_THR_LOW:     thr_low_r  <= THR_W'(cfg_wdata[F:0]);
        fmc_pkg::REG_THR_MID:     thr_mid_r  <= THR_W'(cfg_wdata[F:0]);
        fmc_pkg::REG_THR_HIGH:    thr_high_r <= THR_W'(cfg_wdata[F:0]);
      endcase
    end
  end

  // The pipeline never stalls, so a transaction is taken whenever start is high.
  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Input capture stage.
  logic                 vld0_r;
  logic signed [VW-1:0] sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= in_sample_value;
  end

  // Shape decode: range compares and the dividend and divisor of the face.
  logic signed [VW:0]           x_e, lo_e, hi_e, kn_e;
  logic signed [VW:0]           hi_x, hi_lo, hi_kn, x_lo;
  logic [fmc_pkg::SPREAD_W-1:0] spread_eff;
  fmc_pkg::ctl_t                ctl1_nxt;
  logic [DENW-1:0]              num1_nxt, den1_nxt;

  always_comb begin
    x_e        = (VW+1)'(sample_r);
    lo_e       = (VW+1)'(lower_r);
    hi_e       = (VW+1)'(upper_r);
    kn_e       = (VW+1)'(plateau_r);
    hi_x       = hi_e - x_e;
    hi_lo      = hi_e - lo_e;
    hi_kn      = hi_e - kn_e;
    x_lo       = x_e - lo_e;
    spread_eff = (spread_r == '0) ? 31'd1 : spread_r;
    ctl1_nxt           = '0;
    ctl1_nxt.vld       = vld0_r;
    ctl1_nxt.kind      = fmc_pkg::KIND_FIXED;
    ctl1_nxt.cls       = fmc_pkg::CLS_N;
    num1_nxt           = '0;
    den1_nxt           = DENW'(1);
    unique case (mode_r)
      fmc_pkg::MODE_TRI: begin
        if (sample_r < lower_r || sample_r > upper_r) begin
          ctl1_nxt.cls = fmc_pkg::CLS_N;
        end else if (sample_r == lower_r) begin
          ctl1_nxt.fixed_one = 1'b1;
          ctl1_nxt.cls       = fmc_pkg::CLS_S1;
        end else begin
          ctl1_nxt.kind = fmc_pkg::KIND_RATIO;
          num1_nxt      = DENW'(hi_x[VW-1:0]);
          den1_nxt      = DENW'(hi_lo[VW-1:0]);
        end
      end
      fmc_pkg::MODE_TRAP: begin
        if (sample_r < lower_r || sample_r > upper_r) begin
          ctl1_nxt.cls = fmc_pkg::CLS_N;
        end else if (sample_r <= plateau_r) begin
          ctl1_nxt.fixed_one = 1'b1;
          ctl1_nxt.cls       = fmc_pkg::CLS_S1;
        end else begin
          ctl1_nxt.kind = fmc_pkg::KIND_RATIO;
          num1_nxt      = DENW'(hi_x[VW-1:0]);
          den1_nxt      = DENW'(hi_kn[VW-1:0]);
        end
      end
      fmc_pkg::MODE_GAUSS: begin
        if (sample_r < lower_r) begin
          ctl1_nxt.cls = fmc_pkg::CLS_N;
        end else begin
          // Dividing by sixteen times sigma keeps four integer bits of distance.
          ctl1_nxt.kind = fmc_pkg::KIND_GAUSS;
          num1_nxt      = DENW'(x_lo[VW-1:0]);
          den1_nxt      = DENW'({spread_eff, 4'b0000});
        end
      end
      fmc_pkg::MODE_NONE: begin
        ctl1_nxt.cls = fmc_pkg::CLS_NA;
      end
    endcase
  end

  fmc_pkg::ctl_t   ctl1_r;
  logic [DENW-1:0] num1_r, den1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else begin
      ctl1_r <= ctl1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num1_r <= num1_nxt;
    den1_r <= den1_nxt;
  end

  // Divider entry: a gaussian distance of sixteen sigma or more saturates.
  fmc_pkg::ctl_t   div_ctl_r [0:QS];
  logic [DENW-1:0] div_rem_r [0:QS-1];
  logic [DENW-1:0] div_den_r [0:QS-1];
  logic [QS-1:0]   div_quo_r [1:QS];
  logic            cap2;
  fmc_pkg::ctl_t   ctl2_nxt;

  assign cap2 = (ctl1_r.kind == fmc_pkg::KIND_GAUSS) && (num1_r >= den1_r);

  always_comb begin
    ctl2_nxt     = ctl1_r;
    ctl2_nxt.cap = cap2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_ctl_r[0] <= '0;
    end else begin
      div_ctl_r[0] <= ctl2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_rem_r[0] <= cap2 ? '0 : num1_r;
    div_den_r[0] <= den1_r;
  end

  // Restoring divider, one quotient bit per stage.
  for (genvar j = 0; j < QS; j++) begin : g_div
    logic [QS-1:0]   src_quo;
    logic [DENW:0]   two_r, sub_r;
    logic            ge;

    if (j == 0) begin : g_first
      assign src_quo = '0;
    end else begin : g_rest
      assign src_quo = div_quo_r[j];
    end

    assign two_r = {div_rem_r[j], 1'b0};
    assign sub_r = two_r - {1'b0, div_den_r[j]};
    assign ge    = two_r >= {1'b0, div_den_r[j]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_ctl_r[j+1] <= '0;
      end else begin
        div_ctl_r[j+1] <= div_ctl_r[j];
      end
    end

    always_ff @(posedge clk) begin
      div_quo_r[j+1] <= {src_quo[QS-2:0], ge};
    end

    if (j < QS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        div_rem_r[j+1] <= ge ? sub_r[DENW-1:0] : two_r[DENW-1:0];
        div_den_r[j+1] <= div_den_r[j];
      end
    end
  end

  // Scale the quotient; square the gaussian distance into the exponent t.
  logic [fmc_pkg::D_W-1:0]   d_w;
  logic [2*fmc_pkg::D_W-1:0] d_sq;
  logic [ACC_W-1:0]          pst_acc_nxt;
  fmc_pkg::ctl_t             pst_ctl_r;
  logic [ACC_W-1:0]          pst_acc_r;

  always_comb begin
    d_w  = div_ctl_r[QS].cap ? fmc_pkg::D_CAP :
           fmc_pkg::D_W'(div_quo_r[QS] >> (QS - 20));
    d_sq = d_w * d_w;
    if (div_ctl_r[QS].kind == fmc_pkg::KIND_RATIO) begin
      pst_acc_nxt = ACC_W'(div_quo_r[QS] >> (QS - F));
    end else begin
      pst_acc_nxt = ACC_W'(d_sq[fmc_pkg::D_FRAC_BITS+fmc_pkg::T_W:fmc_pkg::D_FRAC_BITS+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pst_ctl_r <= '0;
    end else begin
      pst_ctl_r <= div_ctl_r[QS];
    end
  end

  always_ff @(posedge clk) begin
    pst_acc_r <= pst_acc_nxt;
  end

  // Series setup: split t into integer part n and fraction f; first term is f.
  fmc_pkg::ctl_t              tay_ctl_r  [0:TAY_ST];
  logic [ACC_W-1:0]           tay_acc_r  [0:TAY_ST];
  logic [fmc_pkg::TERM_W-1:0] tay_val_r  [0:TAY_ST-1];
  logic [fmc_pkg::FRAC_W-1:0] tay_frac_r [0:FRAC_LAST];
  logic [fmc_pkg::TERM_W-1:0] tay_p_r    [0:fmc_pkg::TAYLOR_TERMS-2];
  logic [fmc_pkg::T_W-1:0]    t_q;
  logic                       is_gauss_q;
  fmc_pkg::ctl_t              tay0_nxt;

  assign t_q        = pst_acc_r[fmc_pkg::T_W-1:0];
  assign is_gauss_q = pst_ctl_r.kind == fmc_pkg::KIND_GAUSS;

  always_comb begin
    tay0_nxt        = pst_ctl_r;
    tay0_nxt.g_zero = is_gauss_q && (t_q[23:21] != 3'b000);
    tay0_nxt.g_n    = is_gauss_q ? t_q[20:16] : 5'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tay_ctl_r[0] <= '0;
    end else begin
      tay_ctl_r[0] <= tay0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tay_val_r[0]  <= {t_q[15:0], 16'h0000};
    tay_frac_r[0] <= t_q[15:0];
    tay_acc_r[0]  <= is_gauss_q ? (fmc_pkg::Q32_ONE - ACC_W'({t_q[15:0], 16'h0000}))
                                : pst_acc_r;
  end

  // Series terms two to twelve: multiply by f, divide by k, add or subtract.
  for (genvar i = 0; i < fmc_pkg::TAYLOR_TERMS - 1; i++) begin : g_tay
    localparam int          K     = i + 2;
    localparam logic [32:0] RECIP = 33'(64'h1_0000_0000 / K);
    localparam bit          ADD   = (K % 2) == 0;
    localparam int          SA    = 3 * i;

    logic [47:0] prod_a;
    logic [64:0] prod_b;
    logic [35:0] prod_k;
    logic [5:0]  rem_k;
    logic [31:0] quo_k;
    logic        gauss_c;

    assign prod_a  = tay_val_r[SA] * tay_frac_r[SA];
    assign prod_b  = tay_val_r[SA+1] * RECIP;
    assign prod_k  = 36'(tay_val_r[SA+2]) * 36'(K);
    assign rem_k   = tay_p_r[i][5:0] - prod_k[5:0];
    assign quo_k   = (rem_k >= 6'(K)) ? tay_val_r[SA+2] + 32'd1 : tay_val_r[SA+2];
    assign gauss_c = tay_ctl_r[SA+2].kind == fmc_pkg::KIND_GAUSS;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tay_ctl_r[SA+1] <= '0;
        tay_ctl_r[SA+2] <= '0;
        tay_ctl_r[SA+3] <= '0;
      end else begin
        tay_ctl_r[SA+1] <= tay_ctl_r[SA];
        tay_ctl_r[SA+2] <= tay_ctl_r[SA+1];
        tay_ctl_r[SA+3] <= tay_ctl_r[SA+2];
      end
    end

    always_ff @(posedge clk) begin
      tay_val_r[SA+1] <= prod_a[47:16];
      tay_val_r[SA+2] <= prod_b[63:32];
      tay_p_r[i]      <= tay_val_r[SA+1];
      tay_acc_r[SA+1] <= tay_acc_r[SA];
      tay_acc_r[SA+2] <= tay_acc_r[SA+1];
      if (gauss_c) begin
        tay_acc_r[SA+3] <= ADD ? tay_acc_r[SA+2] + ACC_W'(quo_k)
                               : tay_acc_r[SA+2] - ACC_W'(quo_k);
      end else begin
        tay_acc_r[SA+3] <= tay_acc_r[SA+2];
      end
    end

    if (i < fmc_pkg::TAYLOR_TERMS - 2) begin : g_next
      always_ff @(posedge clk) begin
        tay_val_r[SA+3]  <= quo_k;
        tay_frac_r[SA+1] <= tay_frac_r[SA];
        tay_frac_r[SA+2] <= tay_frac_r[SA+1];
        tay_frac_r[SA+3] <= tay_frac_r[SA+2];
      end
    end
  end

  // Multiply by exp(-1) once for each unit of the integer part n.
  fmc_pkg::ctl_t    exp_ctl_r [1:EXP_N];
  logic [ACC_W-1:0] exp_acc_r [1:EXP_N];

  for (genvar j = 0; j < EXP_N; j++) begin : g_exp
    fmc_pkg::ctl_t    src_ctl;
    logic [ACC_W-1:0] src_acc;
    logic [63:0]      prod_e;
    logic             take;

    if (j == 0) begin : g_first
      assign src_ctl = tay_ctl_r[TAY_ST];
      assign src_acc = tay_acc_r[TAY_ST];
    end else begin : g_rest
      assign src_ctl = exp_ctl_r[j];
      assign src_acc = exp_acc_r[j];
    end

    assign prod_e = src_acc * fmc_pkg::EXP_M1_Q32;
    assign take   = (src_ctl.kind == fmc_pkg::KIND_GAUSS) && (5'(j) < src_ctl.g_n);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        exp_ctl_r[j+1] <= '0;
      end else begin
        exp_ctl_r[j+1] <= src_ctl;
      end
    end

    always_ff @(posedge clk) begin
      exp_acc_r[j+1] <= take ? ACC_W'(prod_e[63:32]) : src_acc;
    end
  end

  // Round the gaussian value to the score precision and saturate at one; fixed and ratio scores pass through.
  logic [ACC_W:0]  rnd_sum, rnd_val;
  logic [SW-1:0]   score_nxt;
  fmc_pkg::ctl_t   rs_ctl_r;
  logic [SW-1:0]   rs_score_r;

  always_comb begin
    rnd_sum = {1'b0, exp_acc_r[EXP_N]} + ((ACC_W+1)'(1) << (31 - F));
    rnd_val = rnd_sum >> (32 - F);
    case (exp_ctl_r[EXP_N].kind)
      fmc_pkg::KIND_FIXED: score_nxt = exp_ctl_r[EXP_N].fixed_one ? SCORE_ONE : '0;
      fmc_pkg::KIND_RATIO: score_nxt = exp_acc_r[EXP_N][F:0];
      fmc_pkg::KIND_GAUSS: begin
        if (exp_ctl_r[EXP_N].g_zero) begin
          score_nxt = '0;
        end else if (rnd_val > (ACC_W+1)'(SCORE_ONE)) begin
          score_nxt = SCORE_ONE;
        end else begin
          score_nxt = rnd_val[F:0];
        end
      end
      default: score_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_ctl_r <= '0;
    end else begin
      rs_ctl_r <= exp_ctl_r[EXP_N];
    end
  end

  always_ff @(posedge clk) begin
    rs_score_r <= score_nxt;
  end

  // Threshold classing and the output register.
  logic                 thr_ok;
  logic [THR_W-1:0]     score_cmp;
  fmc_pkg::suit_class_t cls_nxt;
  logic                 out_valid_r;
  logic [SW-1:0]        out_member_score_r;
  fmc_pkg::suit_class_t out_suit_class_r;

  always_comb begin
    thr_ok    = (thr_low_r <= thr_mid_r) && (thr_mid_r <= thr_high_r) &&
                (thr_high_r <= THR_ONE);
    score_cmp = THR_W'(rs_score_r);
    if (rs_ctl_r.kind == fmc_pkg::KIND_FIXED) begin
      cls_nxt = rs_ctl_r.cls;
    end else if (!thr_ok) begin
      cls_nxt = fmc_pkg::CLS_NA;
    end else if (score_cmp < thr_low_r) begin
      cls_nxt = fmc_pkg::CLS_N;
    end else if (score_cmp < thr_mid_r) begin
      cls_nxt = fmc_pkg::CLS_S3;
    end else if (score_cmp < thr_high_r) begin
      cls_nxt = fmc_pkg::CLS_S2;
    end else begin
      cls_nxt = fmc_pkg::CLS_S1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rs_ctl_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_member_score_r <= rs_score_r;
    out_suit_class_r   <= cls_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_member_score = out_member_score_r;
  assign out_suit_class   = out_suit_class_r;

`ifndef ASSERT_OFF
  // Every result strobe traces back to a transaction a fixed latency earlier.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(accept, LAT))
    else $error("result strobe without a matching start transaction");

  // The divider remainder after the first step must stay below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl_r[1].vld |-> div_rem_r[1] < div_den_r[1])
    else $error("divider remainder not below divisor");

  // Scores never exceed one.
  a_score_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_member_score_r <= SCORE_ONE)
    else $error("membership score above one");

  // With ordered thresholds, class S1 implies a score at or above the top threshold.
  a_s1_score: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && thr_ok && out_suit_class_r == fmc_pkg::CLS_S1) |->
      THR_W'(out_member_score_r) >= thr_high_r)
    else $error("class S1 with a score below the top threshold");
`endif

endmodule

@@ bench/fmc_checker.sv @@
// Checker for the fuzzy membership classifier: it predicts every score and class and compares.
module fmc_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] in_sample_value,
  input  logic               out_valid,
  input  logic [16:0]        out_member_score,
  input  logic [2:0]         out_suit_class,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  output int                 fail_count,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ONE_Q16   = 64'd65536;
  localparam logic [63:0] ONE_Q32   = 64'h1_0000_0000;
  localparam logic [63:0] EXP_NEG_1 = 64'd1580030169;

  typedef struct packed {
    logic [16:0]          score;
    fmc_pkg::suit_class_t cls;
  } grade_t;

  // Shadow copy of the configuration registers.
  fmc_pkg::mf_mode_t  shape;
  logic signed [31:0] lo_edge;
  logic signed [31:0] hi_edge;
  logic signed [31:0] knee;
  logic [30:0]        sigma;
  logic [16:0]        t_low;
  logic [16:0]        t_mid;
  logic [16:0]        t_high;

  grade_t pending_grades[$];

  // Floor of num/den in Q0.16, saturated to one.
  function automatic logic [63:0] slope_ratio(input logic [63:0] num, input logic [63:0] den);
    if (num >= den) return ONE_Q16;
    return (num << 16) / den;
  endfunction

  // Gaussian right face with the series and stepwise exponential of the block.
  function automatic logic [63:0] bell_score(input logic [63:0] diff);
    logic [63:0] s, q, d, t, n, f, term, sum, v;
    s = (sigma == 0) ? 64'd1 : 64'(sigma);
    q = diff / s;
    if (q >= 16) d = 64'd16 << 16;
    else d = (q << 16) + (((diff % s) << 16) / s);
    t = (d * d) >> 17;
    n = t >> 16;
    if (n >= 32) return 0;
    f = (t & 64'hFFFF) << 16;
    term = ONE_Q32;
    sum = ONE_Q32;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * f) >> 32) / k;
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    v = sum;
    for (int k = 0; k < n; k++) v = (v * EXP_NEG_1) >> 32;
    v = (v + (64'd1 << 15)) >> 16;
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

  function automatic fmc_pkg::suit_class_t grade_of(input logic [63:0] s);
    if (!(t_low <= t_mid && t_mid <= t_high && t_high <= 17'd65536)) return fmc_pkg::CLS_NA;
    if (s < t_low) return fmc_pkg::CLS_N;
    if (s < t_mid) return fmc_pkg::CLS_S3;
    if (s < t_high) return fmc_pkg::CLS_S2;
    return fmc_pkg::CLS_S1;
  endfunction

  function automatic grade_t predict_grade(input logic signed [31:0] x);
    grade_t g;
    logic [63:0] s;
    longint xv, lv, hv, kv;
    xv = x;
    lv = lo_edge;
    hv = hi_edge;
    kv = knee;
    g.score = 0;
    g.cls = fmc_pkg::CLS_NA;
    case (shape)
      fmc_pkg::MODE_TRI: begin
        if (xv < lv || xv > hv) g.cls = fmc_pkg::CLS_N;
        else if (xv == lv) begin
          g.score = 17'd65536;
          g.cls = fmc_pkg::CLS_S1;
        end else begin
          s = slope_ratio(64'(hv - xv), 64'(hv - lv));
          g.score = s[16:0];
          g.cls = grade_of(s);
        end
      end
      fmc_pkg::MODE_TRAP: begin
        if (xv < lv || xv > hv) g.cls = fmc_pkg::CLS_N;
        else if (xv <= kv) begin
          g.score = 17'd65536;
          g.cls = fmc_pkg::CLS_S1;
        end else begin
          s = slope_ratio(64'(hv - xv), 64'(hv - kv));
          g.score = s[16:0];
          g.cls = grade_of(s);
        end
      end
      fmc_pkg::MODE_GAUSS: begin
        if (xv < lv) g.cls = fmc_pkg::CLS_N;
        else begin
          s = bell_score(64'(xv - lv));
          g.score = s[16:0];
          g.cls = grade_of(s);
        end
      end
      default: ;
    endcase
    return g;
  endfunction

  assign outstanding = pending_grades.size();

  // Track register writes, predict accepted samples and compare strobed results.
  always @(posedge clk) begin
    grade_t exp_g;
    if (!rst_n) begin
      shape   <= fmc_pkg::MODE_TRI;
      lo_edge <= 0;
      hi_edge <= 32'sd65536;
      knee    <= 0;
      sigma   <= 31'd65536;
      t_low   <= fmc_pkg::THR_LOW_RESET;
      t_mid   <= fmc_pkg::THR_MID_RESET;
      t_high  <= fmc_pkg::THR_HIGH_RESET;
      fail_count <= 0;
    end else begin
      if (start && !busy) pending_grades.push_back(predict_grade(in_sample_value));
      if (out_valid) begin
        if (pending_grades.size() == 0) begin
          $error("result transaction with no expected result");
          fail_count <= fail_count + 1;
        end else begin
          exp_g = pending_grades.pop_front();
          if (out_member_score !== exp_g.score || out_suit_class !== exp_g.cls)
            fail_count <= fail_count + 1;
          if (out_member_score !== exp_g.score)
            $error("member_score: expected %0d, got %0d", exp_g.score, out_member_score);
          if (out_suit_class !== exp_g.cls)
            $error("suit_class: expected %0d, got %0d", exp_g.cls, out_suit_class);
        end
      end
      if (cfg_we) begin
        case (fmc_pkg::cfg_reg_t'(cfg_index))
          fmc_pkg::REG_MF_MODE:     shape   <= fmc_pkg::mf_mode_t'(cfg_wdata[1:0]);
          fmc_pkg::REG_LOWER_EDGE:  lo_edge <= cfg_wdata;
          fmc_pkg::REG_UPPER_EDGE:  hi_edge <= cfg_wdata;
          fmc_pkg::REG_PLATEAU_END: knee    <= cfg_wdata;
          fmc_pkg::REG_SPREAD:      sigma   <= cfg_wdata[30:0];
          fmc_pkg::REG_THR_LOW:     t_low   <= cfg_wdata[16:0];
          fmc_pkg::REG_THR_MID:     t_mid   <= cfg_wdata[16:0];
          fmc_pkg::REG_THR_HIGH:    t_high  <= cfg_wdata[16:0];
          default: ;
        endcase
      end
    end
  end
endmodule

@@ bench/fuzzy_membership_classifier_tb.sv @@
// Testbench top for the fuzzy membership classifier: stimulus, phases and verdict.
module fuzzy_membership_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint INT_MAX = 64'sd2147483647;
  localparam longint INT_MIN = -64'sd2147483648;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_sample_value;
  logic               out_valid;
  logic [16:0]        out_member_score;
  logic [2:0]         out_suit_class;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_wdata;
  int                 fail_count;
  int                 outstanding;

  // Current setting, kept so that samples can be aimed at the shape.
  longint cur_lo, cur_hi, cur_knee, cur_sigma;
  int     gap_pct;

  fuzzy_membership_classifier i_dut (
    .clk, .rst_n, .start, .busy, .in_sample_value, .out_valid,
    .out_member_score, .out_suit_class, .cfg_we, .cfg_index, .cfg_wdata
  );

  fmc_checker i_checker (
    .clk, .rst_n, .start, .busy, .in_sample_value, .out_valid,
    .out_member_score, .out_suit_class, .cfg_we, .cfg_index, .cfg_wdata,
    .fail_count, .outstanding
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Watchdog on the whole run.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic longint clamp32(input longint v);
    if (v > INT_MAX) return INT_MAX;
    if (v < INT_MIN) return INT_MIN;
    return v;
  endfunction

  // Drive one sample transaction; entered and left at a falling edge.
  task automatic send_sample(input longint v);
    start <= 1'b1;
    in_sample_value <= 32'(clamp32(v));
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Random idle cycles before a transaction, by the current gap percentage.
  task automatic maybe_idle();
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // Hold off until every expected result has come back.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all eight registers, one per cycle.
  task automatic load_setting(input fmc_pkg::mf_mode_t m, input longint lo, input longint hi,
                              input longint kn, input longint sg, input int tl,
                              input int tm, input int th);
    logic [31:0] vals[8];
    vals[fmc_pkg::REG_MF_MODE]     = 32'(m);
    vals[fmc_pkg::REG_LOWER_EDGE]  = 32'(lo);
    vals[fmc_pkg::REG_UPPER_EDGE]  = 32'(hi);
    vals[fmc_pkg::REG_PLATEAU_END] = 32'(kn);
    vals[fmc_pkg::REG_SPREAD]      = 32'(sg);
    vals[fmc_pkg::REG_THR_LOW]     = 32'(tl);
    vals[fmc_pkg::REG_THR_MID]     = 32'(tm);
    vals[fmc_pkg::REG_THR_HIGH]    = 32'(th);
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
    cur_knee = kn;
    cur_sigma = (sg == 0) ? 1 : sg;
  endtask

  // Pick a random setting, sometimes at the extremes or with thresholds out of order.
  task automatic random_setting();
    fmc_pkg::mf_mode_t m;
    longint lo, hi, kn, width, sg;
    int t[3], tmp;
    m = ($urandom_range(7) == 0) ? fmc_pkg::MODE_NONE
                                 : fmc_pkg::mf_mode_t'($urandom_range(2));
    case ($urandom_range(5))
      0: begin
        lo = INT_MIN;
        hi = INT_MAX;
      end
      default: begin
        lo = longint'($signed($urandom)) >>> $urandom_range(0, 14);
        width = longint'($urandom >> $urandom_range(0, 24)) + 1;
        hi = clamp32(lo + width);
      end
    endcase
    kn = lo + (hi - lo) * $urandom_range(0, 100) / 100;
    if ($urandom_range(9) == 0) kn = longint'($signed($urandom));
    case ($urandom_range(7))
      0: sg = 0;
      1: sg = INT_MAX;
      2: sg = 1;
      default: sg = longint'($urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(8, 30)) + 1;
    endcase
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(7))
        0: t[i] = 0;
        1: t[i] = 65536;
        default: t[i] = $urandom_range(0, 65536);
      endcase
    end
    if ($urandom_range(4) != 0) begin
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2 - i; j++)
          if (t[j] > t[j + 1]) begin
            tmp = t[j];
            t[j] = t[j + 1];
            t[j + 1] = tmp;
          end
    end
    load_setting(m, lo, hi, kn, sg, t[0], t[1], t[2]);
  endtask

  // One random sample, mostly aimed at the face of the current shape.
  function automatic longint random_sample();
    longint span;
    span = cur_hi - cur_lo;
    if (span < 16 * cur_sigma) span = 16 * cur_sigma;
    if (span < 8) span = 8;
    case ($urandom_range(9))
      0: return longint'($signed($urandom));
      1: return cur_lo + $urandom_range(0, 1);
      2: return cur_knee + $urandom_range(0, 1);
      3: return cur_hi - $urandom_range(0, 1);
      default: return cur_lo - span / 8 + longint'({$urandom, $urandom} % (span + span / 4));
    endcase
  endfunction

  initial begin
    int gaps[3] = '{0, 68, 9};
    longint tri_pts[8] = '{-65536, 131072, -65537, 131073, 0, 65535, INT_MIN, INT_MAX};
    longint trap_pts[5] = '{65536, 65537, 196608, -1, 0};
    longint bell_pts[6] = '{0, -1, 65536, 524288, 1048576, INT_MAX};
    start = 1'b0;
    in_sample_value = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    gap_pct = 0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: triangle edges, outside points and the full value range.
    load_setting(fmc_pkg::MODE_TRI, -65536, 131072, 0, 65536, 16384, 32768, 49152);
    foreach (tri_pts[i])
      send_sample(tri_pts[i]);
    // Trapezoid plateau and its end, extreme thresholds.
    load_setting(fmc_pkg::MODE_TRAP, 0, 196608, 65536, 65536, 0, 65536, 65536);
    foreach (trap_pts[i])
      send_sample(trap_pts[i]);
    // Gaussian: centre, below it, one sigma, capped distance, zero spread.
    load_setting(fmc_pkg::MODE_GAUSS, 0, 0, 0, 65536, 16384, 32768, 49152);
    foreach (bell_pts[i])
      send_sample(bell_pts[i]);
    load_setting(fmc_pkg::MODE_GAUSS, 0, 0, 0, 0, 16384, 32768, 49152);
    send_sample(0);
    send_sample(1);
    // Thresholds out of order, then the unused mode.
    load_setting(fmc_pkg::MODE_TRI, 0, 65536, 0, 65536, 40000, 30000, 20000);
    send_sample(0);
    send_sample(32768);
    load_setting(fmc_pkg::MODE_NONE, 0, 65536, 0, 65536, 16384, 32768, 49152);
    send_sample(100);

    // Random phases, each with its own setting and idle pattern.
    for (int ph = 0; ph < 12; ph++) begin
      random_setting();
      gap_pct = gaps[ph % 3];
      for (int n = 0; n < 105; n++) begin
        if (ph == 4 && n == 50) drain();
        maybe_idle();
        send_sample(random_sample());
      end
    end

    start <= 1'b0;
    for (int w = 0; w < 2000 && outstanding != 0; w++) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
